[rtl/thruster_mixer_with_scaling_core_assert.svh]
// Assertion macros used by the thruster mixer top level.
`ifndef THRUSTER_MIXER_WITH_SCALING_CORE_ASSERT_SVH
`define THRUSTER_MIXER_WITH_SCALING_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TMWS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TMWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tmws_pkg.sv]
// Types and constants of the thruster mixer.
`timescale 1ns / 1ps
package tmws_pkg;

    localparam int NLANE   = 6;
    localparam int NPLANAR = 4;
    localparam int QBITS   = 12;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = 32;
    localparam int T_W     = 33;
    localparam int MAG_W   = 32;
    localparam int U_W     = 33;
    localparam int D_W     = 33;
    localparam int N_W     = U_W + QBITS;
    localparam int SF_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_T0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_T1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_T2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_T3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DMIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DMAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EN   = 3'd6;

    localparam logic [MAG_W-1:0] ONE_Q29 = MAG_W'(64'd1 << 29);
    localparam logic [SF_W-1:0]  SF_ONE  = SF_W'(4096);

    typedef struct packed {
        logic signed [COEF_W-1:0] rc;
        logic signed [COEF_W-1:0] oy;
        logic signed [COEF_W-1:0] ox;
    } coef_t;

    typedef logic signed [T_W-1:0] tval_t;

    typedef struct packed {
        logic [D_W-1:0]                  dvs;
        logic [NLANE-1:0][N_W-1:0]       rem;
        logic [NLANE-1:0][QBITS-1:0]     quo;
        logic                            lim;
        logic [SF_W-1:0]                 sf;
    } divw_t;

endpackage

[rtl/thruster_mixer_with_scaling_core.sv]
// Top level of the thruster mixer with desaturation and PWM duty mapping.
`timescale 1ns / 1ps
// Takes one surge/sway/heave/yaw request per cycle and returns six PWM duties,
// the at_limit flag and the Q4.12 scale factor via 2 mixing, 4 desaturation,
// 12 divider stages (one quotient bit per stage) and the output register.
// Throughput is one request per clock; when the output is not taken the whole
// pipeline holds and s_tready drops. The user must write registers through
// cfg_we/cfg_index/cfg_data only while no request is in flight (not enforced).
`include "thruster_mixer_with_scaling_core_assert.svh"
module thruster_mixer_with_scaling_core
    import tmws_pkg::*;
#(
    parameter int PWM_BITS = 12
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // surge_force, sway_force, heave_force, yaw_torque
    input  logic [63:0]             s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // duty_0, duty_1, duty_2, duty_3, duty_4, duty_5, scale_factor, zero fill
    output logic [((NLANE*PWM_BITS+SF_W+7)/8)*8-1:0] m_tdata,
    // at_limit
    output logic                    m_tuser
);

    localparam int TDATA_W = ((NLANE*PWM_BITS+SF_W+7)/8)*8;

    coef_t [NPLANAR-1:0]   coef_reg;
    logic [QBITS-1:0]      dmin_reg;
    logic [QBITS-1:0]      dmax_reg;
    logic                  en_reg;

    logic                  adv;
    logic [QBITS:0]        span;
    logic                  span_neg;
    logic [QBITS-1:0]      span_abs;
    logic [QBITS:0]        span_n;

    logic                  mix_v;
    tval_t [NLANE-1:0]     mix_t;
    logic                  ds_v;
    divw_t                 ds_d;
    logic                  dv_v;
    divw_t                 dv_d;

    logic                  m_tvalid_reg;
    logic [TDATA_W-1:0]    m_tdata_reg;
    logic [TDATA_W-1:0]    m_tdata_next;
    logic                  m_tuser_reg;

    logic [QBITS:0]        dq  [NLANE];
    logic [QBITS:0]        dsum [NLANE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
            dmin_reg <= '0;
            dmax_reg <= '1;
            en_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_T0:   coef_reg[0] <= cfg_data;
                REG_T1:   coef_reg[1] <= cfg_data;
                REG_T2:   coef_reg[2] <= cfg_data;
                REG_T3:   coef_reg[3] <= cfg_data;
                REG_DMIN: dmin_reg    <= cfg_data[QBITS-1:0];
                REG_DMAX: dmax_reg    <= cfg_data[QBITS-1:0];
                REG_EN:   en_reg      <= cfg_data[0];
                default:  en_reg      <= en_reg;
            endcase
        end
    end

    assign span     = {1'b0, dmax_reg} - {1'b0, dmin_reg};
    assign span_neg = span[QBITS];
    assign span_n   = -span;
    assign span_abs = span_neg ? span_n[QBITS-1:0] : span[QBITS-1:0];

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    tmws_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s_tvalid),
        .surge     (s_tdata[15:0]),
        .sway      (s_tdata[31:16]),
        .heave     (s_tdata[47:32]),
        .yaw       (s_tdata[63:48]),
        .coef      (coef_reg),
        .out_valid (mix_v),
        .t_out     (mix_t)
    );

    tmws_desat u_desat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (mix_v),
        .t_in      (mix_t),
        .span_abs  (span_abs),
        .out_valid (ds_v),
        .out_data  (ds_d)
    );

    tmws_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (ds_v),
        .in_data   (ds_d),
        .out_valid (dv_v),
        .out_data  (dv_d)
    );

    always_comb
    begin
        m_tdata_next = '0;
        for (int i = 0; i < NLANE; i++)
        begin
            dq[i]   = span_neg ? -{1'b0, dv_d.quo[i]} : {1'b0, dv_d.quo[i]};
            dsum[i] = {1'b0, dmin_reg} + dq[i];
            m_tdata_next[i*PWM_BITS +: PWM_BITS] =
                en_reg ? PWM_BITS'(dsum[i][QBITS-1:0]) : '0;
        end
        m_tdata_next[NLANE*PWM_BITS +: SF_W] = dv_d.sf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_tvalid_reg <= dv_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= dv_d.lim;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `TMWS_ASSERT_NOW(a_sf_unity, clk, rst_n, m_tvalid_reg && !m_tuser_reg,
        m_tdata_reg[NLANE*PWM_BITS +: SF_W] == SF_ONE, "scale factor not unity")
    `TMWS_ASSERT_NOW(a_sf_limit, clk, rst_n, m_tvalid_reg && m_tuser_reg,
        m_tdata_reg[NLANE*PWM_BITS +: SF_W] >= SF_ONE, "scale factor below unity")
    `TMWS_ASSERT_NEXT(a_out_load, clk, rst_n, adv && dv_v,
        m_tvalid_reg, "divider result lost")

endmodule

[rtl/tmws_mix.sv]
// Mixing stages: planar-thruster products and their sums, plus the heave lanes.
`timescale 1ns / 1ps
module tmws_mix
    import tmws_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [15:0]              surge,
    input  logic signed [15:0]              sway,
    input  logic signed [15:0]              heave,
    input  logic signed [15:0]              yaw,
    input  coef_t [NPLANAR-1:0]             coef,
    output logic                            out_valid,
    output tval_t [NLANE-1:0]               t_out
);

    logic signed [PROD_W-1:0] prod_reg  [NPLANAR][3];
    logic signed [PROD_W-1:0] prod_next [NPLANAR][3];
    logic signed [15:0]       heave_reg;
    logic                     v1_reg;
    tval_t [NLANE-1:0]        t_reg;
    tval_t [NLANE-1:0]        t_next;
    logic                     v2_reg;

    always_comb
    begin
        for (int i = 0; i < NPLANAR; i++)
        begin
            prod_next[i][0] = surge * coef[i].ox;
            prod_next[i][1] = sway  * coef[i].oy;
            prod_next[i][2] = yaw   * coef[i].rc;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NPLANAR; i++)
        begin
            t_next[i] = T_W'(prod_reg[i][0]) + T_W'(prod_reg[i][1]) + T_W'(prod_reg[i][2]);
        end
        t_next[4] = T_W'(heave_reg) <<< 14;
        t_next[5] = -(T_W'(heave_reg) <<< 14);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            heave_reg <= heave;
            t_reg     <= t_next;
        end
    end

    assign out_valid = v2_reg;
    assign t_out     = t_reg;

endmodule

[rtl/tmws_desat.sv]
// Desaturation stages: largest magnitude, divisor, scale report and numerators.
`timescale 1ns / 1ps
module tmws_desat
    import tmws_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  tval_t [NLANE-1:0]    t_in,
    input  logic [QBITS-1:0]     span_abs,
    output logic                 out_valid,
    output divw_t                out_data
);

    // stage A: magnitudes
    tval_t [NLANE-1:0]          ta_reg;
    logic  [NLANE-1:0][MAG_W-1:0] mag_reg;
    logic  [NLANE-1:0][MAG_W-1:0] mag_next;
    logic                       va_reg;
    // stage B: pairwise maxima
    tval_t [NLANE-1:0]          tb_reg;
    logic  [2:0][MAG_W-1:0]     pmax_reg;
    logic  [2:0][MAG_W-1:0]     pmax_next;
    logic                       vb_reg;
    // stage C: divisor and offset values
    logic  [NLANE-1:0][U_W-1:0] u_reg;
    logic  [NLANE-1:0][U_W-1:0] u_next;
    logic  [D_W-1:0]            d_reg;
    logic                       lim_reg;
    logic  [SF_W-1:0]           sf_reg;
    logic                       vc_reg;
    // stage D: numerators
    divw_t                      dd_reg;
    divw_t                      dd_next;
    logic                       vd_reg;

    logic [MAG_W-1:0]           mx;
    logic [MAG_W-1:0]           mx01;
    logic                       lim;
    logic [MAG_W-1:0]           a;
    logic [MAG_W:0]             sf_sum;
    logic signed [T_W:0]        u_sum [NLANE];
    tval_t                      neg_t [NLANE];

    always_comb
    begin
        for (int i = 0; i < NLANE; i++)
        begin
            neg_t[i]    = -t_in[i];
            mag_next[i] = t_in[i][T_W-1] ? neg_t[i][MAG_W-1:0] : t_in[i][MAG_W-1:0];
        end
        for (int p = 0; p < 3; p++)
        begin
            pmax_next[p] = (mag_reg[2*p] > mag_reg[2*p+1]) ? mag_reg[2*p] : mag_reg[2*p+1];
        end
    end

    always_comb
    begin
        mx01   = (pmax_reg[0] > pmax_reg[1]) ? pmax_reg[0] : pmax_reg[1];
        mx     = (mx01 > pmax_reg[2]) ? mx01 : pmax_reg[2];
        lim    = mx > ONE_Q29;
        a      = lim ? mx : ONE_Q29;
        sf_sum = {1'b0, a} + (MAG_W+1)'(65536);
        for (int i = 0; i < NLANE; i++)
        begin
            u_sum[i]  = (T_W+1)'(tb_reg[i]) + $signed({2'b00, a});
            u_next[i] = u_sum[i][U_W-1:0];
        end
    end

    always_comb
    begin
        dd_next.dvs = d_reg;
        dd_next.lim = lim_reg;
        dd_next.sf  = sf_reg;
        for (int i = 0; i < NLANE; i++)
        begin
            dd_next.rem[i] = N_W'(u_reg[i]) * N_W'(span_abs);
            dd_next.quo[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ta_reg   <= t_in;
            mag_reg  <= mag_next;
            tb_reg   <= ta_reg;
            pmax_reg <= pmax_next;
            u_reg    <= u_next;
            d_reg    <= {a, 1'b0};
            lim_reg  <= lim;
            sf_reg   <= sf_sum[MAG_W:17];
            dd_reg   <= dd_next;
        end
    end

    assign out_valid = vd_reg;
    assign out_data  = dd_reg;

endmodule

[rtl/tmws_div.sv]
// Restoring divider pipeline: one quotient bit per stage for all lanes.
`timescale 1ns / 1ps
module tmws_div
    import tmws_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  divw_t  in_data,
    output logic   out_valid,
    output divw_t  out_data
);

    divw_t pipe_reg [QBITS];
    logic  [QBITS-1:0] vld_reg;

    for (genvar s = 0; s < QBITS; s++)
    begin : g_stage
        localparam int K = QBITS - 1 - s;
        divw_t cur;
        divw_t nxt;
        logic  cur_v;

        if (s == 0)
        begin : g_first
            assign cur   = in_data;
            assign cur_v = in_valid;
        end
        else
        begin : g_rest
            assign cur   = pipe_reg[s-1];
            assign cur_v = vld_reg[s-1];
        end

        always_comb
        begin
            logic [N_W-1:0] shd;
            shd = N_W'(cur.dvs) << K;
            nxt = cur;
            for (int i = 0; i < NLANE; i++)
            begin
                if (cur.rem[i] >= shd)
                begin
                    nxt.rem[i]    = cur.rem[i] - shd;
                    nxt.quo[i][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= cur_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pipe_reg[s] <= nxt;
            end
        end
    end

    assign out_valid = vld_reg[QBITS-1];
    assign out_data  = pipe_reg[QBITS-1];

endmodule
